// ===== rtl/tv_pkg.sv =====
package tv_pkg;

  localparam int MUL_W  = 33;  // signed multiplier operand
  localparam int ACC_W  = 66;  // product / accumulator
  localparam int EDGE_W = 32;  // saturated Q16.16 edge, texture delta, projection
  localparam int NRM_W  = 19;  // normal clamped to +-2.0
  localparam int D_W    = 36;  // rounded dot product
  localparam int DL_W   = 18;  // low split of the dot product
  localparam int MAG_W  = 64;  // tangent component magnitude
  localparam int SCL_W  = 30;  // magnitude after normalizing shift
  localparam int SQ_W   = 62;  // sum of squares
  localparam int ROOT_W = 31;  // integer square root
  localparam int RND_SH = 16;

  localparam logic signed [ACC_W-1:0] SAT_HI   = 66'sd2147483647;
  localparam logic signed [ACC_W-1:0] NRM_HI   = 66'sd131072;
  localparam logic signed [ACC_W-1:0] RND_HALF = 66'sd32768;

  // microprogram layout
  localparam logic [5:0] PC_AC       = 6'd17;
  localparam logic [5:0] PC_WIND     = 6'd34;
  localparam logic [5:0] PC_TANG     = 6'd38;
  localparam logic [5:0] PC_TANG_END = 6'd49;
  localparam logic [5:0] PC_SUM      = 6'd50;
  localparam logic [5:0] PC_SUM_END  = 6'd54;

  typedef enum logic [2:0] {
    MAC_NOP, MAC_LOAD, MAC_ADD, MAC_SUB, MAC_SHADD
  } mac_op_t;

  typedef enum logic [2:0] {
    A_NA, A_PAC, A_PAB, A_MAG, A_DUAB, A_DUAC
  } asel_t;

  typedef enum logic [2:0] {
    B_EAB, B_EAC, B_DH, B_DL, B_DVAB, B_DVAC, B_MAG
  } bsel_t;

  typedef enum logic [2:0] {
    CAP_NONE, CAP_D, CAP_PAB, CAP_PAC, CAP_WIND, CAP_T, CAP_SUM
  } cap_t;

  typedef struct packed {
    asel_t      asel;
    bsel_t      bsel;
    logic [1:0] idx;
    mac_op_t    op;
    cap_t       cap;
  } uop_t;

  typedef struct packed {
    mac_op_t                  op;
    logic signed [MUL_W-1:0]  a;
    logic signed [MUL_W-1:0]  b;
  } mac_req_t;

  localparam uop_t UOP_IDLE = '{asel: A_NA, bsel: B_EAB, idx: 2'd0,
                                op: MAC_NOP, cap: CAP_NONE};

  function automatic logic signed [EDGE_W-1:0] sat_edge(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    y = x;
    if (x > SAT_HI) y = SAT_HI;
    else if (x < -SAT_HI) y = -SAT_HI;
    return y[EDGE_W-1:0];
  endfunction

  function automatic logic signed [NRM_W-1:0] sat_norm(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    y = x;
    if (x > NRM_HI) y = NRM_HI;
    else if (x < -NRM_HI) y = -NRM_HI;
    return y[NRM_W-1:0];
  endfunction

  // round half up, floor shift
  function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] x);
    return (x + RND_HALF) >>> RND_SH;
  endfunction

  function automatic uop_t proj_uop(input logic [5:0] off, input logic is_ac);
    uop_t       u;
    logic [5:0] rel;
    u   = UOP_IDLE;
    rel = off - 6'd5;
    if (off < 6'd3) begin
      u.op   = (off == 6'd0) ? MAC_LOAD : MAC_ADD;
      u.asel = A_NA;
      u.bsel = is_ac ? B_EAC : B_EAB;
      u.idx  = off[1:0];
    end else if (off == 6'd4) begin
      u.cap = CAP_D;
    end else if (off > 6'd4) begin
      u.idx  = rel[3:2];
      u.asel = A_NA;
      case (rel[1:0])
        2'd0: begin
          u.op   = MAC_LOAD;
          u.bsel = B_DH;
        end
        2'd1: begin
          u.op   = MAC_SHADD;
          u.bsel = B_DL;
        end
        2'd2: begin
          u.op = MAC_NOP;
        end
        default: begin
          u.cap = is_ac ? CAP_PAC : CAP_PAB;
        end
      endcase
    end
    return u;
  endfunction

  function automatic uop_t ucode(input logic [5:0] pc);
    uop_t       u;
    logic [5:0] off;
    u = UOP_IDLE;
    if (pc < PC_AC) begin
      u = proj_uop(pc, 1'b0);
    end else if (pc < PC_WIND) begin
      u = proj_uop(pc - PC_AC, 1'b1);
    end else if (pc < PC_TANG) begin
      off = pc - PC_WIND;
      case (off[1:0])
        2'd0: begin
          u.op = MAC_LOAD; u.asel = A_DUAB; u.bsel = B_DVAC;
        end
        2'd1: begin
          u.op = MAC_SUB; u.asel = A_DUAC; u.bsel = B_DVAB;
        end
        2'd2: begin
          u.op = MAC_NOP;
        end
        default: begin
          u.cap = CAP_WIND;
        end
      endcase
    end else if (pc < PC_SUM) begin
      off   = pc - PC_TANG;
      u.idx = off[3:2];
      case (off[1:0])
        2'd0: begin
          u.op = MAC_LOAD; u.asel = A_PAC; u.bsel = B_DVAB;
        end
        2'd1: begin
          u.op = MAC_SUB; u.asel = A_PAB; u.bsel = B_DVAC;
        end
        2'd2: begin
          u.op = MAC_NOP;
        end
        default: begin
          u.cap = CAP_T;
        end
      endcase
    end else begin
      off = pc - PC_SUM;
      if (off < 6'd3) begin
        u.op   = (off == 6'd0) ? MAC_LOAD : MAC_ADD;
        u.asel = A_MAG;
        u.bsel = B_MAG;
        u.idx  = off[1:0];
      end else if (off == 6'd4) begin
        u.cap = CAP_SUM;
      end
    end
    return u;
  endfunction

endpackage

// ===== rtl/triangle_tangent_vector.sv =====
// Channel   Dir  Width  Content (low bit up)
// s_axis    in   256    pos_x pos_y pos_z norm_x norm_y norm_z tex_u tex_v, 32b each
// m_axis    out  48+1   tdata: tangent_x tangent_y tangent_z, 16b each; tuser: degenerate
//
// Corners A and B of a triangle are stored on arrival. Corner C runs a
// microprogram on one shared 33x33 multiply-accumulate unit, a 6-step
// leading-zero search, a shift of each magnitude, a sum of squares, a
// bit-serial square root (31 steps), three restoring divisions and an
// output step; a zero tangent goes from the search straight to output.
// s_axis_tready is low meanwhile, and the output step waits while the
// previous result is still stalled on m_axis.
// Reset is synchronous and restarts at corner A. The result register lets
// the next triangle be taken while a result is stalled on m_axis.
module triangle_tangent_vector #(
  parameter int COORD_WIDTH   = 32,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                       // tex_u, tex_v
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,   // tangent_x, tangent_y, tangent_z
  output logic [0:0]   m_axis_tuser    // degenerate
);

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = tv_pkg::ACC_W;
  localparam int MW    = tv_pkg::MUL_W;
  localparam int QB    = OUT_FRAC_BITS + 1;
  localparam int NUM_W = tv_pkg::SCL_W + OUT_FRAC_BITS + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MAC   = 8'b00000010,
    S_LZ    = 8'b00000100,
    S_SCALE = 8'b00001000,
    S_SUM   = 8'b00010000,
    S_SQRT  = 8'b00100000,
    S_DIV   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  function automatic logic [CW-1:0] take(input logic [31:0] v);
    logic [63:0] z;
    z = {32'b0, v};
    return z[CW-1:0];
  endfunction

  function automatic logic signed [AW-1:0] wide(input logic [CW-1:0] v);
    return AW'($signed(v));
  endfunction

  state_t state;
  logic   launch;
  logic   s_acc;

  // triangle corner stores
  logic [1:0]                           corner_count;
  logic [CW-1:0]                        first_pos  [3];
  logic signed [tv_pkg::NRM_W-1:0]      na         [3];
  logic [CW-1:0]                        first_tc   [2];
  logic [CW-1:0]                        second_pos [3];
  logic [CW-1:0]                        second_tc  [2];
  logic [CW-1:0]                        in_pos     [3];
  logic [CW-1:0]                        in_nrm     [3];
  logic [CW-1:0]                        in_tc      [2];

  // datapath registers
  logic signed [tv_pkg::EDGE_W-1:0] eab [3];
  logic signed [tv_pkg::EDGE_W-1:0] eac [3];
  logic signed [tv_pkg::EDGE_W-1:0] pab [3];
  logic signed [tv_pkg::EDGE_W-1:0] pac [3];
  logic signed [tv_pkg::EDGE_W-1:0] duab, duac, dvab, dvac;
  logic signed [tv_pkg::D_W-1:0]    d;
  logic [tv_pkg::MAG_W-1:0]         mag [3];
  logic [2:0]                       tneg;
  logic [tv_pkg::MAG_W-1:0]         mx;
  logic [5:0]                       lz;
  logic [2:0]                       lzk;
  logic [tv_pkg::SCL_W-1:0]         sm  [3];
  logic [tv_pkg::SQ_W-1:0]          sum;
  logic [tv_pkg::ROOT_W-1:0]        len;
  logic [15:0]                      tan [3];
  logic                             deg;
  logic [1:0]                       idx;
  logic [5:0]                       pc;

  tv_pkg::uop_t                     u;
  tv_pkg::mac_req_t                 req;
  logic signed [MW-1:0]             opa, opb;
  logic signed [AW-1:0]             acc;
  logic [AW-1:0]                    acc_abs;
  logic signed [AW-1:0]             acc_rnd;
  logic                             run_mac;

  logic [5:0]                       lz_s;
  logic                             lz_hit;

  logic                             sqrt_done;
  logic [tv_pkg::ROOT_W-1:0]        sqrt_r;
  logic [NUM_W-1:0]                 div_num;
  logic                             div_done;
  logic [QB-1:0]                    div_q;
  logic [63:0]                      q64;
  logic [63:0]                      qs;

  genvar gi;
  generate
    for (gi = 0; gi < 3; gi++) begin : g_in3
      assign in_pos[gi] = take(s_axis_tdata[32*gi +: 32]);
      assign in_nrm[gi] = take(s_axis_tdata[32*(gi+3) +: 32]);
    end
    for (gi = 0; gi < 2; gi++) begin : g_in2
      assign in_tc[gi] = take(s_axis_tdata[32*(gi+6) +: 32]);
    end
  endgenerate

  assign s_axis_tready = (state == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // ---- microprogram and shared MAC ----
  assign run_mac = (state == S_MAC) || (state == S_SUM);
  assign u       = run_mac ? tv_pkg::ucode(pc) : tv_pkg::UOP_IDLE;

  always_comb begin
    case (u.asel)
      tv_pkg::A_NA:   opa = MW'(na[u.idx]);
      tv_pkg::A_PAC:  opa = MW'(pac[u.idx]);
      tv_pkg::A_PAB:  opa = MW'(pab[u.idx]);
      tv_pkg::A_MAG:  opa = MW'(sm[u.idx]);
      tv_pkg::A_DUAB: opa = MW'(duab);
      tv_pkg::A_DUAC: opa = MW'(duac);
      default:        opa = '0;
    endcase
    case (u.bsel)
      tv_pkg::B_EAB:  opb = MW'(eab[u.idx]);
      tv_pkg::B_EAC:  opb = MW'(eac[u.idx]);
      tv_pkg::B_DH:   opb = MW'($signed(d[tv_pkg::D_W-1:tv_pkg::DL_W]));
      tv_pkg::B_DL:   opb = MW'(d[tv_pkg::DL_W-1:0]);
      tv_pkg::B_DVAB: opb = MW'(dvab);
      tv_pkg::B_DVAC: opb = MW'(dvac);
      tv_pkg::B_MAG:  opb = MW'(sm[u.idx]);
      default:        opb = '0;
    endcase
  end

  assign req.op = u.op;
  assign req.a  = opa;
  assign req.b  = opb;

  tv_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (req),
    .acc (acc)
  );

  assign acc_abs = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign acc_rnd = tv_pkg::rnd16(acc);

  // leading-zero search step: 32, 16, 8, 4, 2, 1
  assign lz_s   = 6'd32 >> lzk;
  assign lz_hit = (mx >> (7'd64 - {1'b0, lz_s})) == '0;

  // ---- square root and division ----
  tv_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (launch && state == S_SQRT),
    .x_in  (sum),
    .done  (sqrt_done),
    .root  (sqrt_r)
  );

  assign div_num = NUM_W'({sm[idx], {OUT_FRAC_BITS{1'b0}}}) + NUM_W'(len >> 1);

  tv_div #(
    .QB    (QB),
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (launch && state == S_DIV),
    .num   (div_num),
    .den   (len),
    .done  (div_done),
    .q     (div_q)
  );

  assign q64 = 64'(div_q);
  assign qs  = tneg[idx] ? (64'd0 - q64) : q64;

  // ---- control ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      corner_count  <= 2'd0;
      launch        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      launch <= 1'b0;
      // S_OUT owns tvalid while it loads the result register
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            case (corner_count)
              2'd0:    corner_count <= 2'd1;
              2'd1:    corner_count <= 2'd2;
              default: begin
                corner_count <= 2'd0;
                state        <= S_MAC;
              end
            endcase
          end
        end
        S_MAC: begin
          if (pc == tv_pkg::PC_TANG_END) state <= S_LZ;
        end
        S_LZ: begin
          if (lzk == 3'd0 && mx == '0) state <= S_OUT;
          else if (lzk == 3'd5) state <= S_SCALE;
        end
        S_SCALE: begin
          if (idx == 2'd2) state <= S_SUM;
        end
        S_SUM: begin
          if (pc == tv_pkg::PC_SUM_END) begin
            state  <= S_SQRT;
            launch <= 1'b1;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            state  <= S_DIV;
            launch <= 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (idx == 2'd2) state <= S_OUT;
            else launch <= 1'b1;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    if (s_acc) begin
      case (corner_count)
        2'd0: begin
          for (int i = 0; i < 3; i++) begin
            first_pos[i] <= in_pos[i];
            na[i]        <= tv_pkg::sat_norm(wide(in_nrm[i]));
          end
          first_tc[0] <= in_tc[0];
          first_tc[1] <= in_tc[1];
        end
        2'd1: begin
          for (int i = 0; i < 3; i++) second_pos[i] <= in_pos[i];
          second_tc[0] <= in_tc[0];
          second_tc[1] <= in_tc[1];
        end
        default: begin
          for (int i = 0; i < 3; i++) begin
            eab[i] <= tv_pkg::sat_edge(wide(second_pos[i]) - wide(first_pos[i]));
            eac[i] <= tv_pkg::sat_edge(wide(in_pos[i]) - wide(first_pos[i]));
          end
          duab <= tv_pkg::sat_edge(wide(second_tc[0]) - wide(first_tc[0]));
          duac <= tv_pkg::sat_edge(wide(in_tc[0]) - wide(first_tc[0]));
          dvab <= tv_pkg::sat_edge(wide(second_tc[1]) - wide(first_tc[1]));
          dvac <= tv_pkg::sat_edge(wide(in_tc[1]) - wide(first_tc[1]));
          pc   <= '0;
        end
      endcase
    end

    if (run_mac) begin
      pc <= pc + 6'd1;
      case (u.cap)
        tv_pkg::CAP_D:   d <= acc_rnd[tv_pkg::D_W-1:0];
        tv_pkg::CAP_PAB: pab[u.idx] <= tv_pkg::sat_edge(AW'(eab[u.idx]) - acc_rnd);
        tv_pkg::CAP_PAC: pac[u.idx] <= tv_pkg::sat_edge(AW'(eac[u.idx]) - acc_rnd);
        tv_pkg::CAP_WIND: begin
          // winding flips both v deltas
          if (acc > 0) begin
            dvab <= -dvab;
            dvac <= -dvac;
          end
        end
        tv_pkg::CAP_T: begin
          tneg[u.idx] <= acc[AW-1];
          mag[u.idx]  <= acc_abs[tv_pkg::MAG_W-1:0];
          if (u.idx == 2'd0 || acc_abs[tv_pkg::MAG_W-1:0] > mx) begin
            mx <= acc_abs[tv_pkg::MAG_W-1:0];
          end
        end
        tv_pkg::CAP_SUM: sum <= acc[tv_pkg::SQ_W-1:0];
        default: ;
      endcase
    end

    if (state == S_MAC && pc == tv_pkg::PC_TANG_END) begin
      lzk <= 3'd0;
      lz  <= 6'd0;
    end

    if (state == S_LZ) begin
      if (lzk == 3'd0 && mx == '0) begin
        for (int i = 0; i < 3; i++) tan[i] <= '0;
        deg <= 1'b1;
      end else begin
        if (lz_hit) begin
          mx <= mx << lz_s;
          lz <= lz + lz_s;
        end
        lzk <= lzk + 3'd1;
        idx <= 2'd0;
        deg <= 1'b0;
      end
    end

    if (state == S_SCALE) begin
      // bring the largest magnitude into [2^29, 2^30)
      if (lz < 6'd34) sm[idx] <= tv_pkg::SCL_W'(mag[idx] >> (6'd34 - lz));
      else sm[idx] <= tv_pkg::SCL_W'(mag[idx] << (lz - 6'd34));
      idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
      pc  <= tv_pkg::PC_SUM;
    end

    if (state == S_SQRT && sqrt_done) len <= sqrt_r;

    if (state == S_DIV && div_done) begin
      tan[idx] <= qs[15:0];
      idx      <= idx + 2'd1;
    end

    if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {tan[2], tan[1], tan[0]};
      m_axis_tuser <= deg;
    end
  end

`ifndef SYNTHESIS
  localparam logic [QB-1:0] Q_ONE = QB'(1) << OUT_FRAC_BITS;

  a_corner_range: assert property (@(posedge clk) disable iff (rst)
    corner_count != 2'd3)
    else $error("corner counter out of range");

  a_root_norm: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> sqrt_r[tv_pkg::ROOT_W-1:tv_pkg::ROOT_W-2] != 2'b00)
    else $error("root below normalized range");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_q <= Q_ONE)
    else $error("quotient above unit length");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata == '0)
    else $error("degenerate result carries nonzero tangent");
`endif

endmodule

// ===== rtl/tv_mac.sv =====
module tv_mac (
  input  logic                             clk,
  input  logic                             rst,
  input  tv_pkg::mac_req_t                 req,
  output logic signed [tv_pkg::ACC_W-1:0]  acc
);

  logic signed [tv_pkg::MUL_W-1:0] ma;
  logic signed [tv_pkg::MUL_W-1:0] mb;
  logic signed [tv_pkg::ACC_W-1:0] prod;
  logic signed [tv_pkg::ACC_W-1:0] p;
  tv_pkg::mac_op_t                 op_r;

  assign ma   = req.a;
  assign mb   = req.b;
  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    p <= prod;
    if (rst) begin
      op_r <= tv_pkg::MAC_NOP;
    end else begin
      op_r <= req.op;
    end
  end

  always_ff @(posedge clk) begin
    case (op_r)
      tv_pkg::MAC_LOAD:  acc <= p;
      tv_pkg::MAC_ADD:   acc <= acc + p;
      tv_pkg::MAC_SUB:   acc <= acc - p;
      tv_pkg::MAC_SHADD: acc <= (acc <<< tv_pkg::DL_W) + p;
      default:           acc <= acc;
    endcase
  end

endmodule

// ===== rtl/tv_isqrt.sv =====
module tv_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tv_pkg::SQ_W-1:0]     x_in,
  output logic                        done,
  output logic [tv_pkg::ROOT_W-1:0]   root
);

  localparam int W = tv_pkg::SQ_W;

  logic [W-1:0] x;
  logic [W-1:0] r;
  logic [W-1:0] b;
  logic [W-1:0] trial;
  logic         busy;

  assign trial = r + b;
  assign root  = r[tv_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && b[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x_in;
      r <= '0;
      b <= W'(1) << (W - 2);
    end else if (busy) begin
      if (x >= trial) begin
        x <= x - trial;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

endmodule

// ===== rtl/tv_div.sv =====
module tv_div #(
  parameter int QB    = 15,
  parameter int NUM_W = 45
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [NUM_W-1:0]            num,
  input  logic [tv_pkg::ROOT_W-1:0]   den,
  output logic                        done,
  output logic [QB-1:0]               q
);

  localparam int RW  = tv_pkg::ROOT_W + 1;
  localparam int CNW = $clog2(QB + 1);

  logic [RW-1:0]  rem;
  logic [RW:0]    rem2;
  logic [RW:0]    diff;
  logic           ge;
  logic [QB-1:0]  lowp;
  logic [CNW-1:0] cnt;
  logic           busy;

  assign rem2 = {rem, lowp[QB-1]};
  assign diff = rem2 - (RW + 1)'(den);
  assign ge   = rem2 >= (RW + 1)'(den);
  assign q    = lowp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNW'(QB - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= RW'(num[NUM_W-1:QB]);
      lowp <= num[QB-1:0];
      cnt  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[RW-1:0] : rem2[RW-1:0];
      lowp <= {lowp[QB-2:0], ge};
      cnt  <= cnt + CNW'(1);
    end
  end

endmodule
